// ----- rtl/core/pwsm_pkg.sv -----
// ----------------------------------------------------------------------------
// pwsm_pkg
// Types and constants shared by the pulse window speed meter.
// ----------------------------------------------------------------------------
`default_nettype none

package pwsm_pkg;

  localparam int unsigned PeriodW = 32;
  localparam int unsigned SpeedW  = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 32;

  // Time / 1000 is at most 4294967, which needs 23 bits.
  localparam int unsigned DenW = 23;
  // Pulses * 60000 is at most 15300000, which needs 24 bits.
  localparam int unsigned NumW = 24;

  localparam logic [31:0] TimeDiv    = 32'd1000;
  localparam logic [31:0] SpeedScale = 32'd60000;
  // floor(2**41 / 1000); the product shifted by 41 is the quotient or one less.
  localparam logic [31:0] DivRecip   = 32'd2199023255;
  localparam int unsigned DivShift   = 41;

  localparam logic [SpeedW-1:0] SpeedMax = '1;
  localparam logic [CountW-1:0] CountMax = '1;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgPulseLimit   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeLimit    = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgMinWindowTime = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgTimeoutPolls = 8'd3;

  // Reset values of the configuration registers.
  localparam logic [CountW-1:0]  RstPulseLimit    = 8'd100;
  localparam logic [PeriodW-1:0] RstTimeLimit     = 32'd2000000;
  localparam logic [PeriodW-1:0] RstMinWindowTime = 32'd1000;
  localparam logic [CountW-1:0]  RstTimeoutPolls  = 8'd5;

  typedef enum logic [1:0] {
    OP_CAPTURE,
    OP_SKIP,
    OP_POLL
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CORR,
    ST_DIV,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    op_e                op;
    logic [PeriodW-1:0] period;
  } queue_item_t;

  typedef struct packed {
    logic [CountW-1:0]  pulse_limit;
    logic [PeriodW-1:0] time_limit;
    logic [PeriodW-1:0] min_window_time;
    logic [CountW-1:0]  timeout_polls;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/pwsm_in_if.sv -----
// ----------------------------------------------------------------------------
// pwsm_in_if
// Input channel: capture events and speed polls.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwsm_in_if
  import pwsm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               command;
  logic [PeriodW-1:0] captured_period;
  logic               pin_high;

  modport source (output valid, output command, output captured_period,
                  output pin_high, input ready);
  modport sink   (input valid, input command, input captured_period,
                  input pin_high, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pwsm_out_if.sv -----
// ----------------------------------------------------------------------------
// pwsm_out_if
// Output channel: one result word per input word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwsm_out_if
  import pwsm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SpeedW-1:0]  speed;
  logic [PeriodW-1:0] total_pulses;
  logic               window_latched;
  logic               speed_updated;

  modport source (output valid, output speed, output total_pulses,
                  output window_latched, output speed_updated, input ready);
  modport sink   (input valid, input speed, input total_pulses,
                  input window_latched, input speed_updated, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pwsm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// pwsm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwsm_cfg_if
  import pwsm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pwsm_front.sv -----
// ----------------------------------------------------------------------------
// pwsm_front
// Accepts input words, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pwsm_front
  import pwsm_pkg::*;
(
  pwsm_in_if.sink     in_i,
  output logic        push_valid_o,
  output queue_item_t push_item_o,
  input  logic        push_ready_i
);

  op_e op;

  // A capture with the pin high changes nothing and is sent on as a skip.
  always_comb begin
    if (in_i.command) begin
      op = OP_POLL;
    end else if (in_i.pin_high) begin
      op = OP_SKIP;
    end else begin
      op = OP_CAPTURE;
    end
  end

  assign in_i.ready         = push_ready_i;
  assign push_valid_o       = in_i.valid;
  assign push_item_o.op     = op;
  assign push_item_o.period = in_i.captured_period;

endmodule

`default_nettype wire

// ----- rtl/core/pwsm_fifo.sv -----
// ----------------------------------------------------------------------------
// pwsm_fifo
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pwsm_fifo
  import pwsm_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  input  queue_item_t push_item_i,
  output logic        push_ready_o,
  output logic        pop_valid_o,
  output queue_item_t pop_item_o,
  input  logic        pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  queue_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pwsm_div.sv -----
// ----------------------------------------------------------------------------
// pwsm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwsm_div
  import pwsm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned StepW = $clog2(NumW + 1);

  logic [NumW-1:0]  num_q;
  logic [DenW-1:0]  rem_q;
  logic [DenW-1:0]  den_q;
  logic [StepW-1:0] steps_q;
  logic             busy_q;
  logic             done_q;

  logic [DenW:0]   trial;
  logic            fits;
  logic [DenW:0]   diff;

  // The remainder stays below the divisor, so it always fits DenW bits.
  assign trial = {rem_q, num_q[NumW-1]};
  assign fits  = (trial >= {1'b0, den_q});
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      steps_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        steps_q <= StepW'(NumW);
      end else if (busy_q) begin
        steps_q <= steps_q - 1'b1;
        if (steps_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DenW-1:0] : trial[DenW-1:0];
      num_q <= {num_q[NumW-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

`default_nettype wire

// ----- rtl/core/pwsm_back.sv -----
// ----------------------------------------------------------------------------
// pwsm_back
// Carries out queued words: window accumulation, posts and speed updates.
// ----------------------------------------------------------------------------
`default_nettype none

module pwsm_back
  import pwsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        pop_valid_i,
  input  queue_item_t pop_item_i,
  output logic        pop_ready_o,
  output div_req_t    div_req_o,
  input  div_rsp_t    div_rsp_i,
  pwsm_out_if.source  out_o
);

  back_state_e state_q, state_d;

  logic [PeriodW-1:0] sum_q, sum_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [PeriodW-1:0] total_q, total_d;
  logic [CountW-1:0]  lpulses_q, lpulses_d;
  logic [PeriodW-1:0] ltime_q, ltime_d;
  logic               new_q, new_d;
  logic [CountW-1:0]  posts_q, posts_d;
  logic [CountW-1:0]  missed_q, missed_d;
  logic [SpeedW-1:0]  speed_q, speed_d;
  logic [63:0]        prod_q, prod_d;
  logic [SpeedW-1:0]  qres_q, qres_d;

  logic               out_valid_q, out_valid_d;
  logic [SpeedW-1:0]  out_speed_q, out_speed_d;
  logic [PeriodW-1:0] out_total_q, out_total_d;
  logic               out_latched_q, out_latched_d;
  logic               out_updated_q, out_updated_d;
  logic               out_load;
  logic               out_free;

  logic [PeriodW-1:0] cap_sum;
  logic [CountW-1:0]  cap_cnt;
  logic               cap_latch;
  logic [DenW-1:0]    q_est;
  logic [PeriodW-1:0] q_scaled;
  logic [PeriodW-1:0] q_rem;
  logic [DenW-1:0]    den;
  logic [NumW-1:0]    num;
  logic [SpeedW-1:0]  quot_sat;

  assign out_free  = !out_valid_q || out_o.ready;

  assign cap_sum   = sum_q + pop_item_i.period;
  assign cap_cnt   = cnt_q + 1'b1;
  assign cap_latch = (cap_cnt == cfg_i.pulse_limit) || (cap_sum > cfg_i.time_limit);

  // Time / 1000 by reciprocal: the estimate is exact or one low.
  assign q_est    = prod_q[DivShift +: DenW];
  assign q_scaled = 32'(q_est) * TimeDiv;
  assign q_rem    = ltime_q - q_scaled;
  assign den      = q_est + DenW'(q_rem >= TimeDiv);
  assign num      = NumW'(32'(lpulses_q) * SpeedScale);
  assign quot_sat = (div_rsp_i.quot[NumW-1:SpeedW] != '0) ? SpeedMax
                                                          : div_rsp_i.quot[SpeedW-1:0];

  always_comb begin
    state_d       = state_q;
    sum_d         = sum_q;
    cnt_d         = cnt_q;
    total_d       = total_q;
    lpulses_d     = lpulses_q;
    ltime_d       = ltime_q;
    new_d         = new_q;
    posts_d       = posts_q;
    missed_d      = missed_q;
    speed_d       = speed_q;
    prod_d        = prod_q;
    qres_d        = qres_q;
    pop_ready_o   = 1'b0;
    div_req_o     = '0;
    out_load      = 1'b0;
    out_speed_d   = speed_q;
    out_total_d   = total_q;
    out_latched_d = 1'b0;
    out_updated_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i && out_free) begin
          pop_ready_o = 1'b1;
          unique case (pop_item_i.op)
            OP_SKIP: begin
              out_load = 1'b1;
            end
            OP_CAPTURE: begin
              total_d     = total_q + 1'b1;
              out_total_d = total_d;
              out_load    = 1'b1;
              if (cap_latch) begin
                ltime_d       = cap_sum;
                lpulses_d     = cap_cnt;
                sum_d         = '0;
                cnt_d         = '0;
                new_d         = 1'b1;
                out_latched_d = 1'b1;
                if (posts_q != CountMax) begin
                  posts_d = posts_q + 1'b1;
                end
              end else begin
                sum_d = cap_sum;
                cnt_d = cap_cnt;
              end
            end
            OP_POLL: begin
              if (posts_q == '0) begin
                if (missed_q != CountMax) begin
                  missed_d = missed_q + 1'b1;
                end
                if (missed_q > cfg_i.timeout_polls) begin
                  speed_d = '0;
                end
                out_speed_d = speed_d;
                out_load    = 1'b1;
              end else begin
                posts_d  = posts_q - 1'b1;
                missed_d = '0;
                if ((ltime_q > cfg_i.min_window_time) && new_q) begin
                  new_d   = 1'b0;
                  state_d = ST_MUL;
                end else begin
                  out_load = 1'b1;
                end
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_MUL: begin
        prod_d  = 64'(ltime_q) * 64'(DivRecip);
        state_d = ST_CORR;
      end
      ST_CORR: begin
        if (den == '0) begin
          qres_d  = SpeedMax;
          state_d = ST_DONE;
        end else begin
          div_req_o.start = 1'b1;
          div_req_o.num   = num;
          div_req_o.den   = den;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          qres_d  = quot_sat;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          speed_d       = qres_q;
          out_speed_d   = qres_q;
          out_updated_d = 1'b1;
          out_load      = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      total_q     <= '0;
      lpulses_q   <= '0;
      ltime_q     <= '0;
      new_q       <= 1'b0;
      posts_q     <= '0;
      missed_q    <= '0;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      lpulses_q   <= lpulses_d;
      ltime_q     <= ltime_d;
      new_q       <= new_d;
      posts_q     <= posts_d;
      missed_q    <= missed_d;
      speed_q     <= speed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    qres_q <= qres_d;
    if (out_load) begin
      out_speed_q   <= out_speed_d;
      out_total_q   <= out_total_d;
      out_latched_q <= out_latched_d;
      out_updated_q <= out_updated_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.speed          = out_speed_q;
  assign out_o.total_pulses   = out_total_q;
  assign out_o.window_latched = out_latched_q;
  assign out_o.speed_updated  = out_updated_q;

endmodule

`default_nettype wire

// ----- rtl/core/pulse_window_speed_meter.sv -----
// ----------------------------------------------------------------------------
// pulse_window_speed_meter
// Reciprocal frequency counter: window of capture periods and polled speed.
// ----------------------------------------------------------------------------
//   channel  dir  handshake      payload
//   cfg_i    in   valid/ready    index, data (registers 0..3)
//   in_i     in   valid/ready    command, captured_period, pin_high
//   out_o    out  valid/ready    speed, total_pulses, window_latched,
//                                speed_updated
//
// Captures and idle polls are handled in the back end's idle state. A poll that
// computes a new speed runs the reciprocal multiply for time / 1000, then the
// one-bit-per-cycle divider (24 steps), and takes no new word meanwhile.
// Reset clears the control and counter state and loads the register defaults;
// no clearing pass. The input queue and the output register let either side stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_window_speed_meter
  import pwsm_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pwsm_cfg_if.sink   cfg_i,
  pwsm_in_if.sink    in_i,
  pwsm_out_if.source out_o
);

  cfg_t        cfg_q;
  logic        push_valid;
  queue_item_t push_item;
  logic        push_ready;
  logic        pop_valid;
  queue_item_t pop_item;
  logic        pop_ready;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_limit     <= RstPulseLimit;
      cfg_q.time_limit      <= RstTimeLimit;
      cfg_q.min_window_time <= RstMinWindowTime;
      cfg_q.timeout_polls   <= RstTimeoutPolls;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgPulseLimit:    cfg_q.pulse_limit     <= cfg_i.data[CountW-1:0];
        CfgTimeLimit:     cfg_q.time_limit      <= cfg_i.data[PeriodW-1:0];
        CfgMinWindowTime: cfg_q.min_window_time <= cfg_i.data[PeriodW-1:0];
        CfgTimeoutPolls:  cfg_q.timeout_polls   <= cfg_i.data[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  pwsm_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  pwsm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  pwsm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pwsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
